>>> rtl/rsps_pkg.sv
// ----------------------------------------------------------------------------
// rsps_pkg: shared types and constants of the resonance sweep peak search
// Command, result and register types, reset values and code names used by
// the interfaces, the register file and the sweep engine.
// ----------------------------------------------------------------------------
`default_nettype none

package rsps_pkg;

	// Default number of current samples averaged at one sweep point.
	localparam int unsigned RSPS_AVG_SAMPLES = 8;

	// Register port geometry: five 16-bit or narrower registers at 4-byte pitch.
	localparam int unsigned RSPS_ADDR_W = 5;
	localparam int unsigned RSPS_DATA_W = 32;

	// Field widths.
	localparam int unsigned INC_W   = 16;
	localparam int unsigned LEVEL_W = 12;
	localparam int unsigned TICK_W  = 16;

	// Register reset values.
	localparam logic [INC_W-1:0]   START_RST  = 16'd0;
	localparam logic [INC_W-1:0]   END_RST    = 16'hFFFF;
	localparam logic [INC_W-1:0]   STEP_RST   = 16'd1;
	localparam logic [TICK_W-1:0]  DWELL_RST  = 16'd10;
	localparam logic [LEVEL_W-1:0] THRESH_RST = 12'd2048;

	// Register indexes (byte address divided by four).
	typedef enum logic [2:0] {
		REG_SWEEP_START = 3'd0,
		REG_SWEEP_END   = 3'd1,
		REG_SWEEP_STEP  = 3'd2,
		REG_DWELL       = 3'd3,
		REG_THRESHOLD   = 3'd4
	} rsps_reg_t;

	// Command codes carried by a request.
	typedef enum logic [1:0] {
		ACT_SWEEP  = 2'd0,
		ACT_CHECK  = 2'd1,
		ACT_TICK   = 2'd2,
		ACT_SAMPLE = 2'd3
	} rsps_action_t;

	// Sequencer phase.
	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_DWELL  = 2'd1,
		PH_SAMPLE = 2'd2
	} rsps_phase_t;

	typedef struct packed {
		rsps_action_t         action;
		logic [INC_W-1:0]     check_inc;
		logic [LEVEL_W-1:0]   current_sample;
	} rsps_cmd_t;

	typedef struct packed {
		logic [INC_W-1:0]     drive_inc;
		logic                 drive_enable;
		logic                 want_sample;
		logic                 busy_res;
		logic                 sweep_done;
		logic                 resonance_found;
		logic [INC_W-1:0]     best_point_inc;
		logic [LEVEL_W-1:0]   peak_level;
		logic                 check_done;
		logic [LEVEL_W-1:0]   avg_level;
	} rsps_res_t;

	typedef struct packed {
		logic [INC_W-1:0]     sweep_start_inc;
		logic [INC_W-1:0]     sweep_end_inc;
		logic [INC_W-1:0]     sweep_step_inc;
		logic [TICK_W-1:0]    dwell_ticks;
		logic [LEVEL_W-1:0]   found_threshold;
	} rsps_cfg_t;

endpackage

`default_nettype wire

>>> rtl/rsps_cmd_if.sv
// ----------------------------------------------------------------------------
// rsps_cmd_if: command channel
// Valid/ready channel that carries one command request per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsps_cmd_if;
	logic                valid;
	logic                ready;
	rsps_pkg::rsps_cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/rsps_res_if.sv
// ----------------------------------------------------------------------------
// rsps_res_if: result channel
// Valid/ready channel that carries one status report per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsps_res_if;
	logic                valid;
	logic                ready;
	rsps_pkg::rsps_res_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/rsps_cfg.sv
// ----------------------------------------------------------------------------
// rsps_cfg: sweep configuration registers
// APB-style register file holding the sweep range, step, dwell and threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module rsps_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [rsps_pkg::RSPS_ADDR_W-1:0]  paddr,
	input  wire logic [rsps_pkg::RSPS_DATA_W-1:0]  pwdata,
	output logic      [rsps_pkg::RSPS_DATA_W-1:0]  prdata,
	output logic                                   pready,
	output rsps_pkg::rsps_cfg_t                    cfg
);
	import rsps_pkg::*;

	rsps_cfg_t cfg_q;
	rsps_reg_t reg_idx;
	logic      wr_en;

	// Word index of the access; the two low address bits are ignored.
	assign reg_idx = rsps_reg_t'(paddr[RSPS_ADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// Register writes complete in the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sweep_start_inc <= START_RST;
			cfg_q.sweep_end_inc   <= END_RST;
			cfg_q.sweep_step_inc  <= STEP_RST;
			cfg_q.dwell_ticks     <= DWELL_RST;
			cfg_q.found_threshold <= THRESH_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SWEEP_START: cfg_q.sweep_start_inc <= pwdata[INC_W-1:0];
				REG_SWEEP_END:   cfg_q.sweep_end_inc   <= pwdata[INC_W-1:0];
				REG_SWEEP_STEP:  cfg_q.sweep_step_inc  <= pwdata[INC_W-1:0];
				REG_DWELL:       cfg_q.dwell_ticks     <= pwdata[TICK_W-1:0];
				REG_THRESHOLD:   cfg_q.found_threshold <= pwdata[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// Read-back mux; unused addresses read as zero.
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_SWEEP_START: prdata = RSPS_DATA_W'(cfg_q.sweep_start_inc);
			REG_SWEEP_END:   prdata = RSPS_DATA_W'(cfg_q.sweep_end_inc);
			REG_SWEEP_STEP:  prdata = RSPS_DATA_W'(cfg_q.sweep_step_inc);
			REG_DWELL:       prdata = RSPS_DATA_W'(cfg_q.dwell_ticks);
			REG_THRESHOLD:   prdata = RSPS_DATA_W'(cfg_q.found_threshold);
			default:         prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> rtl/rsps_avg_div.sv
// ----------------------------------------------------------------------------
// rsps_avg_div: sample average by constant divisor
// Truncating division of the sample sum by the sample count, done as one
// multiplication by a rounded-up reciprocal that is exact over the sum range.
// ----------------------------------------------------------------------------
`default_nettype none

module rsps_avg_div #(
	parameter int unsigned AVG_SAMPLES = rsps_pkg::RSPS_AVG_SAMPLES,
	parameter int unsigned SUM_W       = rsps_pkg::LEVEL_W + $clog2(AVG_SAMPLES)
) (
	input  wire logic [SUM_W-1:0]               sum,
	output logic      [rsps_pkg::LEVEL_W-1:0]   avg
);
	import rsps_pkg::*;

	// Shift of sum width plus divisor bits makes the rounded-up reciprocal exact.
	localparam int unsigned SHIFT  = SUM_W + $clog2(AVG_SAMPLES);
	localparam logic [63:0] RECIP  = ((64'd1 << SHIFT) + 64'(AVG_SAMPLES) - 64'd1)
	                                 / 64'(AVG_SAMPLES);
	localparam int unsigned PROD_W = 2 * SUM_W + 1;

	logic [SUM_W:0]    recip;
	logic [PROD_W-1:0] prod;

	assign recip = RECIP[SUM_W:0];
	assign prod  = PROD_W'(sum) * PROD_W'(recip);
	assign avg   = prod[SHIFT +: LEVEL_W];

endmodule

`default_nettype wire

>>> rtl/rsps_engine.sv
// ----------------------------------------------------------------------------
// rsps_engine: sweep and check sequencer
// Input register, one-step state update of the dwell/sample/peak sequencer,
// and the result register that decouples a stalled receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module rsps_engine #(
	parameter int unsigned AVG_SAMPLES = rsps_pkg::RSPS_AVG_SAMPLES
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rsps_pkg::rsps_cfg_t cfg,
	rsps_cmd_if.sink                 cmd,
	rsps_res_if.source               res
);
	import rsps_pkg::*;

	localparam int unsigned CNT_W = $clog2(AVG_SAMPLES + 1);
	localparam int unsigned SUM_W = LEVEL_W + $clog2(AVG_SAMPLES);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(AVG_SAMPLES);

	// Input stage.
	rsps_cmd_t cmd_s1;
	logic      cmd_valid_s1;

	// Result stage.
	rsps_res_t res_q;
	logic      res_valid_q;

	// Sequencer state.
	rsps_phase_t        phase_q, phase_d;
	logic               check_q, check_d;
	logic [INC_W-1:0]   step_q, step_d;
	logic [TICK_W-1:0]  tick_q, tick_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [SUM_W-1:0]   sum_q, sum_d;
	logic [INC_W-1:0]   best_inc_q, best_inc_d;
	logic [LEVEL_W-1:0] best_lvl_q, best_lvl_d;
	logic [LEVEL_W-1:0] last_avg_q, last_avg_d;
	logic               found_q, found_d;
	logic               enable_q, enable_d;
	logic               sdone, cdone;

	logic               advance, fire;
	logic [INC_W-1:0]   step_amt;
	logic [INC_W:0]     next_pt;
	logic [SUM_W-1:0]   sum_add;
	logic [CNT_W-1:0]   cnt_add;
	logic [TICK_W-1:0]  tick_add;
	logic [LEVEL_W-1:0] avg;
	logic               new_best;
	logic [LEVEL_W-1:0] pt_best_lvl;
	logic [INC_W-1:0]   pt_best_inc;
	rsps_phase_t        point_phase;

	// The result register frees up when empty or when its report is taken.
	assign advance   = !res_valid_q || res.ready;
	assign fire      = cmd_valid_s1 && advance;
	assign cmd.ready = !cmd_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			cmd_valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1 <= cmd.data;
		end
	end

	// Shared arithmetic of the update step.
	assign step_amt = (cfg.sweep_step_inc == '0) ? INC_W'(1) : cfg.sweep_step_inc;
	assign next_pt  = {1'b0, step_q} + {1'b0, step_amt};
	assign sum_add  = sum_q + SUM_W'(cmd_s1.current_sample);
	assign cnt_add  = cnt_q + CNT_W'(1);
	assign tick_add = tick_q + TICK_W'(1);
	assign point_phase = (cfg.dwell_ticks == '0) ? PH_SAMPLE : PH_DWELL;

	rsps_avg_div #(
		.AVG_SAMPLES (AVG_SAMPLES),
		.SUM_W       (SUM_W)
	) u_avg_div (
		.sum (sum_add),
		.avg (avg)
	);

	// Peak tracking keeps the first strictly highest average.
	assign new_best    = avg > best_lvl_q;
	assign pt_best_lvl = new_best ? avg : best_lvl_q;
	assign pt_best_inc = new_best ? step_q : best_inc_q;

	// Next state for the request held in the input stage.
	always_comb begin
		phase_d    = phase_q;
		check_d    = check_q;
		step_d     = step_q;
		tick_d     = tick_q;
		cnt_d      = cnt_q;
		sum_d      = sum_q;
		best_inc_d = best_inc_q;
		best_lvl_d = best_lvl_q;
		last_avg_d = last_avg_q;
		found_d    = found_q;
		enable_d   = enable_q;
		sdone      = 1'b0;
		cdone      = 1'b0;

		unique case (cmd_s1.action)
			ACT_SWEEP: begin
				enable_d   = 1'b1;
				check_d    = 1'b0;
				found_d    = 1'b0;
				step_d     = cfg.sweep_start_inc;
				best_inc_d = cfg.sweep_start_inc;
				best_lvl_d = '0;
				tick_d     = '0;
				cnt_d      = '0;
				sum_d      = '0;
				if (cfg.sweep_start_inc > cfg.sweep_end_inc) begin
					// Empty range: the sweep ends at once with a zero peak.
					sdone   = 1'b1;
					phase_d = PH_IDLE;
					if (cfg.found_threshold == '0) begin
						found_d = 1'b1;
					end else begin
						enable_d = 1'b0;
					end
				end else begin
					phase_d = point_phase;
				end
			end
			ACT_CHECK: begin
				check_d = 1'b1;
				step_d  = cmd_s1.check_inc;
				tick_d  = '0;
				cnt_d   = '0;
				sum_d   = '0;
				phase_d = point_phase;
			end
			ACT_TICK: begin
				if (phase_q == PH_DWELL) begin
					tick_d = tick_add;
					if (tick_add >= cfg.dwell_ticks) begin
						phase_d = PH_SAMPLE;
					end
				end
			end
			ACT_SAMPLE: begin
				if (phase_q == PH_SAMPLE) begin
					sum_d = sum_add;
					cnt_d = cnt_add;
					if (cnt_add >= CNT_LAST) begin
						last_avg_d = avg;
						if (check_q) begin
							phase_d = PH_IDLE;
							cdone   = 1'b1;
						end else begin
							best_lvl_d = pt_best_lvl;
							best_inc_d = pt_best_inc;
							if (next_pt[INC_W] || (next_pt[INC_W-1:0] > cfg.sweep_end_inc)) begin
								// Last point: judge the peak and lock or stop.
								sdone   = 1'b1;
								phase_d = PH_IDLE;
								if (pt_best_lvl >= cfg.found_threshold) begin
									found_d = 1'b1;
									step_d  = pt_best_inc;
								end else begin
									found_d  = 1'b0;
									enable_d = 1'b0;
								end
							end else begin
								step_d  = next_pt[INC_W-1:0];
								tick_d  = '0;
								cnt_d   = '0;
								sum_d   = '0;
								phase_d = point_phase;
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	// State registers advance once per processed request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			check_q    <= 1'b0;
			step_q     <= '0;
			tick_q     <= '0;
			cnt_q      <= '0;
			sum_q      <= '0;
			best_inc_q <= '0;
			best_lvl_q <= '0;
			last_avg_q <= '0;
			found_q    <= 1'b0;
			enable_q   <= 1'b0;
		end else if (fire) begin
			phase_q    <= phase_d;
			check_q    <= check_d;
			step_q     <= step_d;
			tick_q     <= tick_d;
			cnt_q      <= cnt_d;
			sum_q      <= sum_d;
			best_inc_q <= best_inc_d;
			best_lvl_q <= best_lvl_d;
			last_avg_q <= last_avg_d;
			found_q    <= found_d;
			enable_q   <= enable_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= cmd_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.drive_inc       <= step_d;
			res_q.drive_enable    <= enable_d;
			res_q.want_sample     <= (phase_d == PH_SAMPLE);
			res_q.busy_res        <= (phase_d != PH_IDLE);
			res_q.sweep_done      <= sdone;
			res_q.resonance_found <= found_d;
			res_q.best_point_inc  <= best_inc_d;
			res_q.peak_level      <= best_lvl_d;
			res_q.check_done      <= cdone;
			res_q.avg_level       <= last_avg_d;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

endmodule

`default_nettype wire

>>> rtl/resonance_sweep_peak_search_top.sv
// ----------------------------------------------------------------------------
// resonance_sweep_peak_search_top: drive-frequency sweep with peak search
//
// Commands enter on the cmd channel (valid/ready): start sweep, start check,
// millisecond tick and current sample. Every accepted request yields exactly
// one status report on the res channel, in order, carrying the drive
// increment and enable, sampling and busy flags, done pulses, the peak found
// so far and the last average.
// An accepted request is held in the input register; its report is loaded
// into the result register once that register is free, and is then valid on
// the res channel.
// A new request is taken in every cycle while the receiver does not stall;
// the whole state update of one request is combinational, bounded by the
// averaging multiplier feeding the peak compare.
// When the receiver stalls, the held report stays in the result register and
// one more request may wait in the input register; cmd.ready then drops.
// Reset clears the sequencer to idle with the drive disabled and loads the
// register defaults. Registers are written through the APB port at 4*index
// and should be changed only while no sweep or check is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module resonance_sweep_peak_search_top #(
	parameter int unsigned AVG_SAMPLES = rsps_pkg::RSPS_AVG_SAMPLES
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	rsps_cmd_if.sink                               cmd,
	rsps_res_if.source                             res,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [rsps_pkg::RSPS_ADDR_W-1:0]  paddr,
	input  wire logic [rsps_pkg::RSPS_DATA_W-1:0]  pwdata,
	output logic      [rsps_pkg::RSPS_DATA_W-1:0]  prdata,
	output logic                                   pready
);
	import rsps_pkg::*;

	rsps_cfg_t cfg;

	// Configuration register file.
	rsps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sweep and check sequencer.
	rsps_engine #(
		.AVG_SAMPLES (AVG_SAMPLES)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.res    (res)
	);

endmodule

`default_nettype wire

>>> tb/sv/tb_resonance_sweep_peak_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_resonance_sweep_peak_search_top: self-checking bench for the sweep engine
// Drives command requests and register writes, predicts every status report
// with a cycle-free model of the sweep and check sequencer, and compares each
// report field by field in order. A short table of directed requests comes
// first, then randomized sweeps and checks under several stall patterns.
// ----------------------------------------------------------------------------

module tb_resonance_sweep_peak_search_top;
	import rsps_pkg::*;

	localparam int unsigned N_AVG       = RSPS_AVG_SAMPLES;
	localparam int          QUIET_LIMIT = 2000;
	localparam int          ITEM_TARGET = 1850;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		rsps_cmd_t req;
		rsps_cfg_t settings;
		bit        typed;
		rsps_res_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [RSPS_ADDR_W-1:0] paddr;
	logic [RSPS_DATA_W-1:0] pwdata;
	logic [RSPS_DATA_W-1:0] prdata;
	logic pready;

	rsps_cmd_if cmd_ch ();
	rsps_res_if res_ch ();

	resonance_sweep_peak_search_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Free-running 2 ns clock.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow of the register file and of the sequencer state.
	rsps_cfg_t cfg_shadow = '{START_RST, END_RST, STEP_RST, DWELL_RST, THRESH_RST};

	rsps_phase_t        eng_phase      = PH_IDLE;
	logic               eng_check_mode = 1'b0;
	logic [INC_W-1:0]   eng_drive_inc  = '0;
	logic [TICK_W-1:0]  eng_ticks      = '0;
	logic [6:0]         eng_nsamp      = '0;
	logic [17:0]        eng_sum        = '0;
	logic [INC_W-1:0]   eng_best_inc   = '0;
	logic [LEVEL_W-1:0] eng_best_level = '0;
	logic [LEVEL_W-1:0] eng_last_avg   = '0;
	logic               eng_found      = 1'b0;
	logic               eng_enable     = 1'b0;
	bit                 req_ignored;

	rsps_res_t pending_reports[$];
	dir_row_t  dir_rows[$];

	int mismatch_count = 0;
	int reports_seen   = 0;
	int useful_items   = 0;
	int quiet_cycles   = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	// Sample shaping: one base level per sweep point.
	logic [LEVEL_W-1:0] point_base;
	bit                 point_noisy;

	// Restart dwell and averaging for a new operating point.
	function automatic void open_point();
		eng_ticks = '0;
		eng_nsamp = '0;
		eng_sum   = '0;
		eng_phase = (cfg_shadow.dwell_ticks == '0) ? PH_SAMPLE : PH_DWELL;
	endfunction

	// Judge the peak: lock the drive to it or switch the drive off.
	function automatic void close_sweep();
		if (eng_best_level >= cfg_shadow.found_threshold) begin
			eng_found     = 1'b1;
			eng_drive_inc = eng_best_inc;
		end else begin
			eng_found  = 1'b0;
			eng_enable = 1'b0;
		end
		eng_phase = PH_IDLE;
	endfunction

	// Advance the sequencer by one request and return the status it reports.
	function automatic rsps_res_t sweep_engine_step(rsps_cmd_t c);
		rsps_res_t          r;
		logic [16:0]        stp;
		logic [16:0]        nxt;
		logic [LEVEL_W-1:0] avg;
		logic               sdone;
		logic               cdone;
		sdone       = 1'b0;
		cdone       = 1'b0;
		req_ignored = 1'b0;
		case (c.action)
			ACT_SWEEP: begin
				eng_enable     = 1'b1;
				eng_check_mode = 1'b0;
				eng_found      = 1'b0;
				eng_drive_inc  = cfg_shadow.sweep_start_inc;
				eng_best_inc   = cfg_shadow.sweep_start_inc;
				eng_best_level = '0;
				if (cfg_shadow.sweep_start_inc > cfg_shadow.sweep_end_inc) begin
					eng_ticks = '0;
					eng_nsamp = '0;
					eng_sum   = '0;
					close_sweep();
					sdone = 1'b1;
				end else begin
					open_point();
				end
			end
			ACT_CHECK: begin
				eng_check_mode = 1'b1;
				eng_drive_inc  = c.check_inc;
				open_point();
			end
			ACT_TICK: begin
				if (eng_phase == PH_DWELL) begin
					eng_ticks = eng_ticks + 1'b1;
					if (eng_ticks >= cfg_shadow.dwell_ticks)
						eng_phase = PH_SAMPLE;
				end else begin
					req_ignored = 1'b1;
				end
			end
			default: begin
				if (eng_phase == PH_SAMPLE) begin
					eng_sum   = eng_sum + 18'(c.current_sample);
					eng_nsamp = eng_nsamp + 1'b1;
					if (eng_nsamp >= N_AVG) begin
						avg          = LEVEL_W'(eng_sum / N_AVG);
						eng_last_avg = avg;
						if (eng_check_mode) begin
							eng_phase = PH_IDLE;
							cdone     = 1'b1;
						end else begin
							stp = (cfg_shadow.sweep_step_inc == '0) ? 17'd1
								: {1'b0, cfg_shadow.sweep_step_inc};
							nxt = {1'b0, eng_drive_inc} + stp;
							if (avg > eng_best_level) begin
								eng_best_level = avg;
								eng_best_inc   = eng_drive_inc;
							end
							if (nxt > {1'b0, cfg_shadow.sweep_end_inc} || nxt > 17'hFFFF) begin
								close_sweep();
								sdone = 1'b1;
							end else begin
								eng_drive_inc = nxt[INC_W-1:0];
								open_point();
							end
						end
					end
				end else begin
					req_ignored = 1'b1;
				end
			end
		endcase
		r.drive_inc       = eng_drive_inc;
		r.drive_enable    = eng_enable;
		r.want_sample     = (eng_phase == PH_SAMPLE);
		r.busy_res        = (eng_phase != PH_IDLE);
		r.sweep_done      = sdone;
		r.resonance_found = eng_found;
		r.best_point_inc  = eng_best_inc;
		r.peak_level      = eng_best_level;
		r.check_done      = cdone;
		r.avg_level       = eng_last_avg;
		return r;
	endfunction

	function automatic rsps_cmd_t make_req(rsps_action_t a, logic [INC_W-1:0] inc,
		logic [LEVEL_W-1:0] smp);
		rsps_cmd_t c;
		c.action         = a;
		c.check_inc      = inc;
		c.current_sample = smp;
		return c;
	endfunction

	function automatic rsps_cfg_t make_cfg(logic [15:0] s, logic [15:0] e, logic [15:0] st,
		logic [15:0] dw, logic [11:0] th);
		rsps_cfg_t k;
		k.sweep_start_inc = s;
		k.sweep_end_inc   = e;
		k.sweep_step_inc  = st;
		k.dwell_ticks     = dw;
		k.found_threshold = th;
		return k;
	endfunction

	function automatic dir_row_t row_req(rsps_action_t a, logic [15:0] inc, logic [11:0] smp);
		dir_row_t d;
		d.kind     = ROW_REQ;
		d.req      = make_req(a, inc, smp);
		d.settings = '0;
		d.typed    = 1'b0;
		d.want     = '0;
		return d;
	endfunction

	function automatic dir_row_t row_want(rsps_action_t a, logic [15:0] inc, logic [11:0] smp,
		rsps_res_t w);
		dir_row_t d;
		d       = row_req(a, inc, smp);
		d.typed = 1'b1;
		d.want  = w;
		return d;
	endfunction

	function automatic dir_row_t row_cfg(rsps_cfg_t k);
		dir_row_t d;
		d          = row_req(ACT_TICK, '0, '0);
		d.kind     = ROW_CFG;
		d.settings = k;
		return d;
	endfunction

	// One current sample: a base level per point, with ties to the best so far.
	function automatic logic [LEVEL_W-1:0] draw_sample();
		int roll;
		int v;
		if (eng_nsamp == '0) begin
			roll = $urandom_range(0, 99);
			point_noisy = (roll >= 40);
			if (roll < 10)
				point_base = '0;
			else if (roll < 20)
				point_base = 12'hFFF;
			else if (roll < 40)
				point_base = eng_best_level;
			else
				point_base = LEVEL_W'($urandom());
		end
		if (!point_noisy)
			return point_base;
		v = int'(point_base) + int'($urandom_range(0, 64)) - 32;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return LEVEL_W'(v);
	endfunction

	// Random register setting that keeps a sweep to a handful of points.
	function automatic rsps_cfg_t pick_settings();
		rsps_cfg_t   k;
		int unsigned roll;
		int unsigned stp;
		longint      e;
		roll = $urandom_range(0, 99);
		if (roll < 15)
			k.sweep_start_inc = '0;
		else if (roll < 30)
			k.sweep_start_inc = 16'hFFFF - 16'($urandom_range(0, 300));
		else
			k.sweep_start_inc = 16'($urandom());
		roll = $urandom_range(0, 99);
		if (roll < 10)
			k.sweep_step_inc = '0;
		else if (roll < 20)
			k.sweep_step_inc = 16'hFFFF;
		else
			k.sweep_step_inc = 16'($urandom_range(1, (1 << $urandom_range(0, 16)) - 1));
		stp = (k.sweep_step_inc == '0) ? 1 : k.sweep_step_inc;
		if ($urandom_range(0, 99) < 10 && k.sweep_start_inc != '0) begin
			k.sweep_end_inc = 16'($urandom_range(0, k.sweep_start_inc - 1));
		end else begin
			e = longint'(k.sweep_start_inc) + longint'(stp) * $urandom_range(0, 4)
				+ $urandom_range(0, stp - 1);
			k.sweep_end_inc = (e > 65535) ? 16'hFFFF : 16'(e);
		end
		roll = $urandom_range(0, 99);
		if (roll < 30)
			k.dwell_ticks = '0;
		else if (roll < 35)
			k.dwell_ticks = 16'($urandom_range(5, 40));
		else
			k.dwell_ticks = 16'($urandom_range(1, 4));
		roll = $urandom_range(0, 99);
		if (roll < 15)
			k.found_threshold = '0;
		else if (roll < 30)
			k.found_threshold = 12'hFFF;
		else
			k.found_threshold = LEVEL_W'($urandom());
		return k;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("mismatch at report %0d: %s got 0x%0h, expected 0x%0h",
				reports_seen, what, got, want);
	endtask

	task automatic compare_report(input rsps_res_t got, input rsps_res_t want);
		if (got.drive_inc !== want.drive_inc)
			report_mismatch("drive_inc", 32'(got.drive_inc), 32'(want.drive_inc));
		if (got.drive_enable !== want.drive_enable)
			report_mismatch("drive_enable", 32'(got.drive_enable), 32'(want.drive_enable));
		if (got.want_sample !== want.want_sample)
			report_mismatch("want_sample", 32'(got.want_sample), 32'(want.want_sample));
		if (got.busy_res !== want.busy_res)
			report_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
		if (got.sweep_done !== want.sweep_done)
			report_mismatch("sweep_done", 32'(got.sweep_done), 32'(want.sweep_done));
		if (got.resonance_found !== want.resonance_found)
			report_mismatch("resonance_found", 32'(got.resonance_found),
				32'(want.resonance_found));
		if (got.best_point_inc !== want.best_point_inc)
			report_mismatch("best_point_inc", 32'(got.best_point_inc),
				32'(want.best_point_inc));
		if (got.peak_level !== want.peak_level)
			report_mismatch("peak_level", 32'(got.peak_level), 32'(want.peak_level));
		if (got.check_done !== want.check_done)
			report_mismatch("check_done", 32'(got.check_done), 32'(want.check_done));
		if (got.avg_level !== want.avg_level)
			report_mismatch("avg_level", 32'(got.avg_level), 32'(want.avg_level));
	endtask

	// Offer one request, with random sender gaps, and predict its report once taken.
	task automatic push_request(input rsps_cmd_t c, input bit typed = 1'b0,
		input rsps_res_t want = '0);
		rsps_res_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= c;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		predicted = sweep_engine_step(c);
		pending_reports.push_back(typed ? want : predicted);
		if (!req_ignored)
			useful_items++;
	endtask

	// Setup and access phase of one register write; the caller releases psel.
	task automatic write_register(input rsps_reg_t idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			REG_SWEEP_START: cfg_shadow.sweep_start_inc = val[15:0];
			REG_SWEEP_END:   cfg_shadow.sweep_end_inc   = val[15:0];
			REG_SWEEP_STEP:  cfg_shadow.sweep_step_inc  = val[15:0];
			REG_DWELL:       cfg_shadow.dwell_ticks     = val[15:0];
			default:         cfg_shadow.found_threshold = val[11:0];
		endcase
	endtask

	// Let the running operation finish, drain all reports, then load every register.
	task automatic apply_settings(input rsps_cfg_t k);
		while (eng_phase != PH_IDLE) begin
			if (eng_phase == PH_DWELL)
				push_request(make_req(ACT_TICK, 16'($urandom()), 12'($urandom())));
			else
				push_request(make_req(ACT_SAMPLE, 16'($urandom()), draw_sample()));
		end
		cmd_ch.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		write_register(REG_SWEEP_START, {16'($urandom()), k.sweep_start_inc});
		write_register(REG_SWEEP_END,   {16'($urandom()), k.sweep_end_inc});
		write_register(REG_SWEEP_STEP,  {16'($urandom()), k.sweep_step_inc});
		write_register(REG_DWELL,       {16'($urandom()), k.dwell_ticks});
		write_register(REG_THRESHOLD,   {20'($urandom()), k.found_threshold});
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// A sweep or check with stray events and aborts, or one to three random requests.
	task automatic run_episode();
		int roll;
		int n;
		roll = $urandom_range(0, 99);
		if (roll < 65) begin
			push_request(make_req(ACT_SWEEP, 16'($urandom()), 12'($urandom())));
		end else if (roll < 85) begin
			push_request(make_req(ACT_CHECK, 16'($urandom()), 12'($urandom())));
		end else begin
			n = $urandom_range(1, 3);
			repeat (n)
				push_request(make_req(rsps_action_t'($urandom_range(0, 3)),
					16'($urandom()), 12'($urandom())));
			return;
		end
		while (eng_phase != PH_IDLE) begin
			roll = $urandom_range(0, 99);
			if (roll < 3)
				return;
			if (roll < 8) begin
				// Event of the wrong kind for the current phase.
				if (eng_phase == PH_DWELL)
					push_request(make_req(ACT_SAMPLE, 16'($urandom()), 12'($urandom())));
				else
					push_request(make_req(ACT_TICK, 16'($urandom()), 12'($urandom())));
			end else if (eng_phase == PH_DWELL) begin
				push_request(make_req(ACT_TICK, 16'($urandom()), 12'($urandom())));
			end else begin
				push_request(make_req(ACT_SAMPLE, 16'($urandom()), draw_sample()));
			end
		end
	endtask

	// Receiver: random stalls, and in-order comparison of every taken report.
	always @(posedge clk) begin : report_check
		rsps_res_t want;
		res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_reports.size() == 0) begin
				report_mismatch("report with nothing pending", 32'(res_ch.data.drive_inc),
					32'd0);
			end else begin
				want = pending_reports.pop_front();
				compare_report(res_ch.data, want);
			end
			reports_seen++;
		end
	end

	// Watchdog on cycles without any transfer on either channel or the register port.
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout with %0d reports pending", pending_reports.size());
			$display("tb_resonance_sweep_peak_search_top NOT OK");
			$finish;
		end
	end

	initial begin : stimulus
		int send_pcts[4];
		int recv_pcts[4];
		int phase_goal;
		int block_goal;
		send_pcts = '{0, 80, 0, 6};
		recv_pcts = '{0, 0, 80, 6};
		arst_n         = 1'b0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.data    = '0;
		res_ch.ready   = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		point_base     = '0;
		point_noisy    = 1'b0;

		// Stray events right after reset, then a check at the reset settings.
		dir_rows.push_back(row_want(ACT_TICK, 16'h0000, 12'h000, '0));
		dir_rows.push_back(row_want(ACT_SAMPLE, 16'hFFFF, 12'hFFF, '0));
		dir_rows.push_back(row_want(ACT_CHECK, 16'hFFFF, 12'h000,
			rsps_res_t'{16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 12'h000,
				1'b0, 12'h000}));
		// Single point at the top increment, zero dwell, zero step, zero threshold.
		dir_rows.push_back(row_cfg(make_cfg(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 12'h000)));
		dir_rows.push_back(row_req(ACT_SWEEP, 16'h0000, 12'h000));
		repeat (N_AVG - 1)
			dir_rows.push_back(row_req(ACT_SAMPLE, 16'h0000, 12'hFFF));
		dir_rows.push_back(row_want(ACT_SAMPLE, 16'h0000, 12'hFFF,
			rsps_res_t'{16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 16'hFFFF, 12'hFFF,
				1'b0, 12'hFFF}));
		// Start above end with the highest threshold: no point, drive switched off.
		dir_rows.push_back(row_cfg(make_cfg(16'h0001, 16'h0000, 16'h0001, 16'h0000, 12'hFFF)));
		dir_rows.push_back(row_want(ACT_SWEEP, 16'h0000, 12'h000,
			rsps_res_t'{16'h0001, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0001, 12'h000,
				1'b0, 12'hFFF}));
		// Longest dwell, cut short by a sweep command that finishes at once.
		dir_rows.push_back(row_cfg(make_cfg(16'h0001, 16'h0000, 16'h0001, 16'hFFFF, 12'h000)));
		dir_rows.push_back(row_req(ACT_CHECK, 16'h0000, 12'h000));
		dir_rows.push_back(row_req(ACT_TICK, 16'h0000, 12'h000));
		dir_rows.push_back(row_req(ACT_TICK, 16'h0000, 12'h000));
		dir_rows.push_back(row_req(ACT_SAMPLE, 16'h0000, 12'h000));
		dir_rows.push_back(row_req(ACT_SWEEP, 16'h0000, 12'h000));
		// Largest step over the full range, restarted while sampling.
		dir_rows.push_back(row_cfg(make_cfg(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0002, 12'h320)));
		dir_rows.push_back(row_req(ACT_SWEEP, 16'h0000, 12'h000));
		dir_rows.push_back(row_req(ACT_TICK, 16'h0000, 12'h000));
		dir_rows.push_back(row_req(ACT_TICK, 16'h0000, 12'h000));
		dir_rows.push_back(row_req(ACT_TICK, 16'h0000, 12'h000));
		dir_rows.push_back(row_req(ACT_SAMPLE, 16'h0000, 12'hAAA));
		dir_rows.push_back(row_req(ACT_SAMPLE, 16'h0000, 12'h555));
		dir_rows.push_back(row_req(ACT_CHECK, 16'h1234, 12'h000));
		dir_rows.push_back(row_req(ACT_SWEEP, 16'h0000, 12'h000));
		dir_rows.push_back(row_cfg(make_cfg(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0002, 12'h320)));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG)
				apply_settings(dir_rows[i].settings);
			else
				push_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
		end

		// Randomized sweeps and checks under each stall pattern.
		useful_items = 0;
		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = send_pcts[p];
			recv_stall_pct = recv_pcts[p];
			phase_goal     = (ITEM_TARGET * (p + 1)) / 4;
			while (useful_items < phase_goal) begin
				apply_settings(pick_settings());
				block_goal = useful_items + $urandom_range(60, 180);
				while (useful_items < block_goal && useful_items < phase_goal)
					run_episode();
			end
		end

		// Drain and let the pipeline settle.
		cmd_ch.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_resonance_sweep_peak_search_top OK");
		else
			$display("tb_resonance_sweep_peak_search_top NOT OK");
		$finish;
	end

endmodule
